// ===== design/ezlr_pkg.sv =====
// shared types, codes and zone mapping functions for the eight-zone line rasterizer
package ezlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int WIDE_BITS  = COORD_BITS + 1;
  localparam int STEP_BITS  = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic signed [STEP_BITS-1:0]  step_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  typedef enum logic [2:0] {
    ZONE_0 = 3'd0,
    ZONE_1 = 3'd1,
    ZONE_2 = 3'd2,
    ZONE_3 = 3'd3,
    ZONE_4 = 3'd4,
    ZONE_5 = 3'd5,
    ZONE_6 = 3'd6,
    ZONE_7 = 3'd7
  } zone_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef struct packed {
    wide_t a;
    wide_t b;
  } pair_t;

  typedef struct packed {
    zone_t  zone;
    wide_t  a0;
    wide_t  b0;
    wide_t  a1;
    dec_t   dec;
    step_t  step_e;
    step_t  step_ne;
    coord_t pix_x;
    coord_t pix_y;
    logic   last;
  } setup_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    zone_t  zone;
    logic   last_pixel;
  } pix_t;

  function automatic pair_t to_zone0(zone_t z, wide_t x, wide_t y);
    pair_t p;
    case (z)
      ZONE_0: begin p.a = x;  p.b = y;  end
      ZONE_1: begin p.a = y;  p.b = x;  end
      ZONE_2: begin p.a = y;  p.b = -x; end
      ZONE_3: begin p.a = -x; p.b = y;  end
      ZONE_4: begin p.a = -x; p.b = -y; end
      ZONE_5: begin p.a = -y; p.b = -x; end
      ZONE_6: begin p.a = -y; p.b = x;  end
      default: begin p.a = x; p.b = -y; end
    endcase
    return p;
  endfunction

  function automatic pair_t from_zone0(zone_t z, wide_t a, wide_t b);
    pair_t p;
    case (z)
      ZONE_0: begin p.a = a;  p.b = b;  end
      ZONE_1: begin p.a = b;  p.b = a;  end
      ZONE_2: begin p.a = -b; p.b = a;  end
      ZONE_3: begin p.a = -a; p.b = b;  end
      ZONE_4: begin p.a = -a; p.b = -b; end
      ZONE_5: begin p.a = -b; p.b = -a; end
      ZONE_6: begin p.a = b;  p.b = -a; end
      default: begin p.a = a; p.b = -b; end
    endcase
    return p;
  endfunction

endpackage

// ===== design/ezlr_setup.sv =====
// line setup: zone classification, mirroring into zone 0 and midpoint terms
module ezlr_setup (
  input  ezlr_pkg::coord_t x_start,
  input  ezlr_pkg::coord_t y_start,
  input  ezlr_pkg::coord_t x_end,
  input  ezlr_pkg::coord_t y_end,
  output ezlr_pkg::setup_t setup
);
  import ezlr_pkg::*;

  wide_t x0, y0, x1, y1;
  wide_t dx, dy;
  step_t ndx, ndy;
  zone_t zone;
  pair_t p0, p1;
  step_t dxp, dyp;

  always_comb begin
    x0 = wide_t'(x_start);
    y0 = wide_t'(y_start);
    x1 = wide_t'(x_end);
    y1 = wide_t'(y_end);
    dx = x1 - x0;
    dy = y1 - y0;
    ndx = -step_t'(dx);
    ndy = -step_t'(dy);

    if (!dx[WIDE_BITS-1] && !dy[WIDE_BITS-1]) begin
      zone = (dx >= dy) ? ZONE_0 : ZONE_1;
    end else if (dx[WIDE_BITS-1] && !dy[WIDE_BITS-1]) begin
      zone = (ndx >= step_t'(dy)) ? ZONE_3 : ZONE_2;
    end else if (dx[WIDE_BITS-1] && dy[WIDE_BITS-1]) begin
      zone = (ndx >= ndy) ? ZONE_4 : ZONE_5;
    end else begin
      zone = (step_t'(dx) >= ndy) ? ZONE_7 : ZONE_6;
    end

    p0 = to_zone0(zone, x0, y0);
    p1 = to_zone0(zone, x1, y1);
    dxp = step_t'($signed(p1.a)) - step_t'($signed(p0.a));
    dyp = step_t'($signed(p1.b)) - step_t'($signed(p0.b));

    setup.zone    = zone;
    setup.a0      = p0.a;
    setup.b0      = p0.b;
    setup.a1      = p1.a;
    setup.dec     = (dec_t'(dyp) <<< 1) - dec_t'(dxp);
    setup.step_e  = dyp <<< 1;
    setup.step_ne = (dyp - dxp) <<< 1;
    setup.pix_x   = x_start;
    setup.pix_y   = y_start;
    setup.last    = ($signed(p0.a) >= $signed(p1.a));
  end

endmodule

// ===== design/ezlr_walker.sv =====
// midpoint walker: line state, pixel emission and decision update
module ezlr_walker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ezlr_pkg::cmd_t   cmd,
  input  ezlr_pkg::setup_t setup,
  output ezlr_pkg::pix_t   pix
);
  import ezlr_pkg::*;

  logic  busy_r, busy_nxt;
  wide_t cur_major_r, cur_major_nxt;
  wide_t cur_minor_r, cur_minor_nxt;
  wide_t end_major_r, end_major_nxt;
  dec_t  decision_r, decision_nxt;
  step_t step_east_r, step_east_nxt;
  step_t step_ne_r, step_ne_nxt;
  zone_t zone_r, zone_nxt;

  wide_t src_major, src_minor, src_end;
  dec_t  src_dec;
  step_t src_se, src_sne;
  zone_t src_zone;
  logic  active, last;
  pair_t back;

  always_comb begin
    back = from_zone0(zone_r, cur_major_r, cur_minor_r);
    if (cmd == CMD_START) begin
      src_major = setup.a0;
      src_minor = setup.b0;
      src_end   = setup.a1;
      src_dec   = setup.dec;
      src_se    = setup.step_e;
      src_sne   = setup.step_ne;
      src_zone  = setup.zone;
      active    = 1'b1;
      last      = setup.last;
      pix       = '{1'b1, setup.pix_x, setup.pix_y, setup.zone, setup.last};
    end else begin
      src_major = cur_major_r;
      src_minor = cur_minor_r;
      src_end   = end_major_r;
      src_dec   = decision_r;
      src_se    = step_east_r;
      src_sne   = step_ne_r;
      src_zone  = zone_r;
      active    = busy_r;
      last      = (cur_major_r >= end_major_r);
      if (busy_r) begin
        pix = '{1'b1, coord_t'(back.a[COORD_BITS-1:0]), coord_t'(back.b[COORD_BITS-1:0]),
                zone_r, last};
      end else begin
        pix = '{1'b0, '0, '0, ZONE_0, 1'b0};
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    cur_major_nxt = cur_major_r;
    cur_minor_nxt = cur_minor_r;
    end_major_nxt = end_major_r;
    decision_nxt  = decision_r;
    step_east_nxt = step_east_r;
    step_ne_nxt   = step_ne_r;
    zone_nxt      = zone_r;
    if (fire && active) begin
      busy_nxt      = !last;
      cur_major_nxt = src_major + wide_t'(1);
      end_major_nxt = src_end;
      step_east_nxt = src_se;
      step_ne_nxt   = src_sne;
      zone_nxt      = src_zone;
      if (src_dec[DEC_BITS-1]) begin
        cur_minor_nxt = src_minor;
        decision_nxt  = src_dec + dec_t'(src_se);
      end else begin
        cur_minor_nxt = src_minor + wide_t'(1);
        decision_nxt  = src_dec + dec_t'(src_sne);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_major_r <= cur_major_nxt;
    cur_minor_r <= cur_minor_nxt;
    end_major_r <= end_major_nxt;
    decision_r  <= decision_nxt;
    step_east_r <= step_east_nxt;
    step_ne_r   <= step_ne_nxt;
    zone_r      <= zone_nxt;
  end

endmodule

// ===== design/eight_zone_line_rasterizer.sv =====
// top level of the eight-zone midpoint line rasterizer
//
//   channel | handshake            | word
//   in      | in_valid / in_stall  | cmd, x_start, y_start, x_end, y_end
//   out     | out_valid / out_stall| pixel_valid, pixel_x, pixel_y, zone_out, last_pixel
//
// one result word per input word, one word per clock when neither side stalls
// each word passes the input register, then setup and walker into the result register
// the walker state loop closes through its own registers, so back-to-back ticks run at full rate
// synchronous active-low reset clears the valid flags and the busy flag
// a stalled result holds while one more input word can wait in the input register
module eight_zone_line_rasterizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_cmd,
  input  ezlr_pkg::coord_t    in_x_start,
  input  ezlr_pkg::coord_t    in_y_start,
  input  ezlr_pkg::coord_t    in_x_end,
  input  ezlr_pkg::coord_t    in_y_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_pixel_valid,
  output ezlr_pkg::coord_t    out_pixel_x,
  output ezlr_pkg::coord_t    out_pixel_y,
  output logic [2:0]          out_zone_out,
  output logic                out_last_pixel
);
  import ezlr_pkg::*;

  logic   s1_valid_r, s1_valid_nxt;
  cmd_t   s1_cmd_r;
  coord_t s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r;
  logic   out_valid_r, out_valid_nxt;
  pix_t   out_pix_r;

  logic   in_fire, s1_fire, out_load;
  setup_t setup;
  pix_t   pix;

  assign out_load     = !out_valid_r || !out_stall;
  assign s1_fire      = s1_valid_r && out_load;
  assign in_stall     = s1_valid_r && !s1_fire;
  assign in_fire      = in_valid && !in_stall;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = out_load ? s1_fire : out_valid_r;

  ezlr_setup u_setup (
    .x_start (s1_x0_r),
    .y_start (s1_y0_r),
    .x_end   (s1_x1_r),
    .y_end   (s1_y1_r),
    .setup   (setup)
  );

  ezlr_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .cmd   (s1_cmd_r),
    .setup (setup),
    .pix   (pix)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= cmd_t'(in_cmd);
      s1_x0_r  <= in_x_start;
      s1_y0_r  <= in_y_start;
      s1_x1_r  <= in_x_end;
      s1_y1_r  <= in_y_end;
    end
    if (s1_fire) begin
      out_pix_r <= pix;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_pix_r.pixel_valid;
  assign out_pixel_x     = out_pix_r.pixel_x;
  assign out_pixel_y     = out_pix_r.pixel_y;
  assign out_zone_out    = out_pix_r.zone;
  assign out_last_pixel  = out_pix_r.last_pixel;

`ifndef SYNTH
  a_start_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_cmd_r == CMD_START) |=> (out_valid && out_pixel_valid))
    else $error("start word did not produce a pixel");

  a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel_valid) |->
      (out_pixel_x == '0 && out_pixel_y == '0 && out_zone_out == '0 && !out_last_pixel))
    else $error("idle tick word carries nonzero fields");

  a_last_needs_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_pixel && out_valid |-> out_pixel_valid)
    else $error("last flag on an invalid pixel");

  a_pending_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_cmd_r)))
    else $error("waiting input word lost");
`endif

endmodule
